/* rtl/core/slf_pkg.sv */
// Shared constants, types and command structs for the saturating ladder low-pass filter.
package slf_pkg;

	// Fixed-point format of the feedback weights and the stage gains.
	localparam int COEFF_FRAC_BITS = 10;

	// Field and state widths.
	localparam int SAMPLE_W   = 16;
	localparam int RES_W      = 11;
	localparam int CUT_W      = 15;
	localparam int CFG_DATA_W = 15;
	localparam int STATE_W    = 32;
	localparam int NUM_STAGES = 4;
	localparam int NUM_DELAYS = 3;
	localparam int STG_IDX_W  = $clog2(NUM_STAGES);

	// Register indexes of the configuration port.
	localparam logic CFG_RESONANCE = 1'b0;
	localparam logic CFG_CUTOFF    = 1'b1;

	// Feedback weights, truncated to the fixed-point grid.
	localparam int WEIGHT_W = COEFF_FRAC_BITS;
	localparam logic [WEIGHT_W-1:0] W_LAST =
		WEIGHT_W'((64'd360891 << COEFF_FRAC_BITS) / 64'd1000000);
	localparam logic [WEIGHT_W-1:0] W_DLY1 =
		WEIGHT_W'((64'd417290 << COEFF_FRAC_BITS) / 64'd1000000);
	localparam logic [WEIGHT_W-1:0] W_DLY2 =
		WEIGHT_W'((64'd177896 << COEFF_FRAC_BITS) / 64'd1000000);
	localparam logic [WEIGHT_W-1:0] W_DLY3 =
		WEIGHT_W'((64'd439725 << COEFF_FRAC_BITS) / 64'd10000000);

	// Saturation curve: |v| - ceil(|v|^3 / (3 * FullScale^2)).
	localparam int FULL_SCALE = 32767;
	localparam logic [31:0] CUBE_DIV = 32'(64'd3 * 64'd32767 * 64'd32767);
	// Reciprocal for the quotient estimate: (n >> 15) * RECIP >> 32 is at most one low.
	localparam int RECIP_PRE = 15;
	localparam int RECIP_SH  = 32;
	localparam logic [15:0] RECIP = 16'((64'd1 << (RECIP_PRE + RECIP_SH)) / 64'(CUBE_DIV));
	localparam int CUBE_W = 46;
	localparam int QUOT_W = CUBE_W - RECIP_SH;
	localparam int REM_W  = 34;

	// Shared multiplier and the value fed to the saturator.
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int SHP_W   = PROD_W - COEFF_FRAC_BITS;
	localparam int SV_W    = SHP_W + 1;
	localparam int ACC_W   = STATE_W + 2;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FB0,
		ST_FB1,
		ST_FB2,
		ST_FB3,
		ST_FB4,
		ST_KFB,
		ST_SAT_A,
		ST_SAT_SQ,
		ST_SAT_CU,
		ST_SAT_QE,
		ST_SAT_QC,
		ST_SAT_FIX,
		ST_INC,
		ST_UPD,
		ST_OUT
	} ctrl_state_t;

	// Which saturation the shared saturator sequence is working on.
	typedef enum logic [1:0] {
		SJ_IN,
		SJ_OWN,
		SJ_NEW,
		SJ_FB
	} sat_job_t;

	// Operand pair of the shared multiplier.
	typedef enum logic [3:0] {
		MS_NONE,
		MS_S4W,
		MS_D1W,
		MS_D2W,
		MS_D3W,
		MS_KFB,
		MS_SQ,
		MS_CU,
		MS_QE,
		MS_QC,
		MS_INC
	} mul_sel_t;

	typedef enum logic [1:0] {
		SRC_TARGET,
		SRC_STAGE,
		SRC_FB
	} sat_src_t;

	typedef enum logic [1:0] {
		DST_TGT,
		DST_OWN,
		DST_RES
	} sat_dst_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		mul_sel_t               mul_sel;
		logic                   x_ld;
		logic                   acc_ld;
		logic                   acc_add;
		logic                   fb_ld;
		logic                   sat_ld;
		sat_src_t               sat_src;
		logic                   sat_wr;
		sat_dst_t               sat_dst;
		logic                   st_upd;
		logic [STG_IDX_W-1:0]   stage_idx;
		logic                   out_ld;
	} slf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} slf_sts_t;

endpackage

/* rtl/core/slf_in_if.sv */
// Input channel: valid/ready handshake carrying one input sample word.
interface slf_in_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [slf_pkg::SAMPLE_W-1:0]      sample_in;

	modport source(output valid, output sample_in, input ready);
	modport sink(input valid, input sample_in, output ready);
endinterface

/* rtl/core/slf_out_if.sv */
// Output channel: valid/ready handshake carrying one filtered sample word.
interface slf_out_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [slf_pkg::SAMPLE_W-1:0]      sample_out;

	modport source(output valid, output sample_out, input ready);
	modport sink(input valid, input sample_out, output ready);
endinterface

/* rtl/core/slf_ctrl.sv */
// Controller state machine that sequences the shared multiplier and saturator.
module slf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  slf_pkg::slf_sts_t   sts,
	output slf_pkg::slf_cmd_t   cmd
);

	slf_pkg::ctrl_state_t              state_q, state_d;
	slf_pkg::sat_job_t                 job_q, job_d;
	logic [slf_pkg::STG_IDX_W-1:0]     stg_q, stg_d;

	function automatic logic [slf_pkg::STG_IDX_W-1:0] STG_IDX_NEXT(
		input logic [slf_pkg::STG_IDX_W-1:0] idx
	);
		return slf_pkg::STG_IDX_W'(idx + 1'b1);
	endfunction

	// State, saturation job and stage counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slf_pkg::ST_IDLE;
			job_q   <= slf_pkg::SJ_IN;
			stg_q   <= '0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
			stg_q   <= stg_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d       = state_q;
		job_d         = job_q;
		stg_d         = stg_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.stage_idx = stg_q;

		case (state_q)
			slf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.x_ld = 1'b1;
					state_d  = slf_pkg::ST_FB0;
				end
			end
			// Weighted sum of the last stage and its delayed copies.
			slf_pkg::ST_FB0: begin
				cmd.mul_sel = slf_pkg::MS_S4W;
				state_d     = slf_pkg::ST_FB1;
			end
			slf_pkg::ST_FB1: begin
				cmd.mul_sel = slf_pkg::MS_D1W;
				cmd.acc_ld  = 1'b1;
				state_d     = slf_pkg::ST_FB2;
			end
			slf_pkg::ST_FB2: begin
				cmd.mul_sel = slf_pkg::MS_D2W;
				cmd.acc_add = 1'b1;
				state_d     = slf_pkg::ST_FB3;
			end
			slf_pkg::ST_FB3: begin
				cmd.mul_sel = slf_pkg::MS_D3W;
				cmd.acc_add = 1'b1;
				state_d     = slf_pkg::ST_FB4;
			end
			slf_pkg::ST_FB4: begin
				cmd.fb_ld = 1'b1;
				state_d   = slf_pkg::ST_KFB;
			end
			slf_pkg::ST_KFB: begin
				cmd.mul_sel = slf_pkg::MS_KFB;
				job_d       = slf_pkg::SJ_IN;
				stg_d       = '0;
				state_d     = slf_pkg::ST_SAT_A;
			end
			// Saturator sequence: clamp, square, cube, estimate, check, correct.
			slf_pkg::ST_SAT_A: begin
				cmd.sat_ld = 1'b1;
				case (job_q)
					slf_pkg::SJ_IN: cmd.sat_src = slf_pkg::SRC_TARGET;
					slf_pkg::SJ_FB: cmd.sat_src = slf_pkg::SRC_FB;
					default:        cmd.sat_src = slf_pkg::SRC_STAGE;
				endcase
				state_d = slf_pkg::ST_SAT_SQ;
			end
			slf_pkg::ST_SAT_SQ: begin
				cmd.mul_sel = slf_pkg::MS_SQ;
				state_d     = slf_pkg::ST_SAT_CU;
			end
			slf_pkg::ST_SAT_CU: begin
				cmd.mul_sel = slf_pkg::MS_CU;
				state_d     = slf_pkg::ST_SAT_QE;
			end
			slf_pkg::ST_SAT_QE: begin
				cmd.mul_sel = slf_pkg::MS_QE;
				state_d     = slf_pkg::ST_SAT_QC;
			end
			slf_pkg::ST_SAT_QC: begin
				cmd.mul_sel = slf_pkg::MS_QC;
				state_d     = slf_pkg::ST_SAT_FIX;
			end
			slf_pkg::ST_SAT_FIX: begin
				cmd.sat_wr = 1'b1;
				case (job_q)
					slf_pkg::SJ_IN: begin
						cmd.sat_dst = slf_pkg::DST_TGT;
						job_d       = slf_pkg::SJ_OWN;
						state_d     = slf_pkg::ST_SAT_A;
					end
					slf_pkg::SJ_OWN: begin
						cmd.sat_dst = slf_pkg::DST_OWN;
						state_d     = slf_pkg::ST_INC;
					end
					slf_pkg::SJ_NEW: begin
						cmd.sat_dst = slf_pkg::DST_TGT;
						job_d       = slf_pkg::SJ_OWN;
						stg_d       = STG_IDX_NEXT(stg_q);
						state_d     = slf_pkg::ST_SAT_A;
					end
					default: begin
						cmd.sat_dst = slf_pkg::DST_RES;
						state_d     = slf_pkg::ST_OUT;
					end
				endcase
			end
			// Stage increment and update.
			slf_pkg::ST_INC: begin
				cmd.mul_sel = slf_pkg::MS_INC;
				state_d     = slf_pkg::ST_UPD;
			end
			slf_pkg::ST_UPD: begin
				cmd.st_upd = 1'b1;
				if (stg_q == slf_pkg::STG_IDX_W'(slf_pkg::NUM_STAGES - 1)) begin
					job_d = slf_pkg::SJ_FB;
				end else begin
					job_d = slf_pkg::SJ_NEW;
				end
				state_d = slf_pkg::ST_SAT_A;
			end
			slf_pkg::ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = slf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = slf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/slf_dpath.sv */
// Datapath: configuration, filter state, shared multiplier, saturator and output register.
module slf_dpath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    wr_en,
	input  logic                                    wr_index,
	input  logic [slf_pkg::CFG_DATA_W-1:0]          wr_data,
	input  logic signed [slf_pkg::SAMPLE_W-1:0]     sample_in,
	input  slf_pkg::slf_cmd_t                       cmd,
	output slf_pkg::slf_sts_t                       sts,
	input  logic                                    out_ready,
	output logic                                    out_valid,
	output logic signed [slf_pkg::SAMPLE_W-1:0]     sample_out
);

	logic [slf_pkg::RES_W-1:0]                  res_gain_q;
	logic [slf_pkg::CUT_W-1:0]                  cut_gain_q;
	logic signed [slf_pkg::STATE_W-1:0]         st_q [slf_pkg::NUM_STAGES];
	logic signed [slf_pkg::STATE_W-1:0]         dl_q [slf_pkg::NUM_DELAYS];
	logic signed [slf_pkg::SAMPLE_W-1:0]        x_q;
	logic signed [slf_pkg::ACC_W-1:0]           acc_q;
	logic signed [slf_pkg::STATE_W-1:0]         fb_q;
	logic signed [slf_pkg::PROD_W-1:0]          prod_q;
	logic [slf_pkg::SAMPLE_W-1:0]               sa_q;
	logic                                       sneg_q;
	logic [slf_pkg::CUBE_W-1:0]                 n_q;
	logic [slf_pkg::QUOT_W-1:0]                 q0_q;
	logic signed [slf_pkg::SAMPLE_W-1:0]        tgt_q;
	logic signed [slf_pkg::SAMPLE_W-1:0]        own_q;
	logic signed [slf_pkg::SAMPLE_W-1:0]        res_q;
	logic                                       out_valid_q;
	logic signed [slf_pkg::SAMPLE_W-1:0]        out_data_q;

	logic signed [slf_pkg::MUL_A_W-1:0]         mul_a;
	logic signed [slf_pkg::MUL_B_W-1:0]         mul_b;
	logic signed [slf_pkg::PROD_W-1:0]          prod_d;
	logic signed [slf_pkg::SHP_W-1:0]           prod_sh;
	logic signed [slf_pkg::SAMPLE_W:0]          diff;
	logic signed [slf_pkg::SV_W-1:0]            sat_v;
	logic signed [slf_pkg::SAMPLE_W:0]          clamp_v;
	logic [slf_pkg::SAMPLE_W-1:0]               sa_d;
	logic [slf_pkg::REM_W-1:0]                  rem0;
	logic [slf_pkg::REM_W-1:0]                  rem1;
	logic                                       rem_ge;
	logic [slf_pkg::QUOT_W:0]                   q_ceil;
	logic [slf_pkg::SAMPLE_W-1:0]               mag;
	logic signed [slf_pkg::SAMPLE_W-1:0]        sat_res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_gain_q <= slf_pkg::RES_W'(102);
			cut_gain_q <= slf_pkg::CUT_W'(704);
		end else if (wr_en) begin
			case (wr_index)
				slf_pkg::CFG_RESONANCE: res_gain_q <= wr_data[slf_pkg::RES_W-1:0];
				slf_pkg::CFG_CUTOFF:    cut_gain_q <= wr_data[slf_pkg::CUT_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier operand selection.
	assign diff = (slf_pkg::SAMPLE_W + 1)'(tgt_q) - (slf_pkg::SAMPLE_W + 1)'(own_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			slf_pkg::MS_S4W: begin
				mul_a = slf_pkg::MUL_A_W'(st_q[slf_pkg::NUM_STAGES-1]);
				mul_b = slf_pkg::MUL_B_W'($signed({1'b0, slf_pkg::W_LAST}));
			end
			slf_pkg::MS_D1W: begin
				mul_a = slf_pkg::MUL_A_W'(dl_q[0]);
				mul_b = slf_pkg::MUL_B_W'($signed({1'b0, slf_pkg::W_DLY1}));
			end
			slf_pkg::MS_D2W: begin
				mul_a = slf_pkg::MUL_A_W'(dl_q[1]);
				mul_b = slf_pkg::MUL_B_W'($signed({1'b0, slf_pkg::W_DLY2}));
			end
			slf_pkg::MS_D3W: begin
				mul_a = slf_pkg::MUL_A_W'(dl_q[2]);
				mul_b = slf_pkg::MUL_B_W'($signed({1'b0, slf_pkg::W_DLY3}));
			end
			slf_pkg::MS_KFB: begin
				// Feedback gain is four times the resonance register.
				mul_a = slf_pkg::MUL_A_W'(fb_q);
				mul_b = slf_pkg::MUL_B_W'($signed({1'b0, res_gain_q, 2'b00}));
			end
			slf_pkg::MS_SQ: begin
				mul_a = slf_pkg::MUL_A_W'($signed({1'b0, sa_q}));
				mul_b = slf_pkg::MUL_B_W'($signed({1'b0, sa_q}));
			end
			slf_pkg::MS_CU: begin
				mul_a = slf_pkg::MUL_A_W'($signed({1'b0, prod_q[2*slf_pkg::SAMPLE_W-2:0]}));
				mul_b = slf_pkg::MUL_B_W'($signed({1'b0, sa_q}));
			end
			slf_pkg::MS_QE: begin
				mul_a = slf_pkg::MUL_A_W'($signed({1'b0,
					prod_q[slf_pkg::CUBE_W-1:slf_pkg::RECIP_PRE]}));
				mul_b = slf_pkg::MUL_B_W'($signed({1'b0, slf_pkg::RECIP}));
			end
			slf_pkg::MS_QC: begin
				mul_a = slf_pkg::MUL_A_W'($signed({1'b0, slf_pkg::CUBE_DIV}));
				mul_b = slf_pkg::MUL_B_W'($signed({1'b0,
					prod_q[slf_pkg::CUBE_W-1:slf_pkg::RECIP_SH]}));
			end
			slf_pkg::MS_INC: begin
				mul_a = slf_pkg::MUL_A_W'(diff);
				mul_b = slf_pkg::MUL_B_W'($signed({1'b0, cut_gain_q}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d  = mul_a * mul_b;
	assign prod_sh = slf_pkg::SHP_W'(prod_q >>> slf_pkg::COEFF_FRAC_BITS);

	// Saturator front end: pick the operand, clamp to the sample range, take magnitude.
	always_comb begin
		case (cmd.sat_src)
			slf_pkg::SRC_TARGET: sat_v = slf_pkg::SV_W'(x_q) - slf_pkg::SV_W'(prod_sh);
			slf_pkg::SRC_STAGE:  sat_v = slf_pkg::SV_W'(st_q[cmd.stage_idx]);
			slf_pkg::SRC_FB:     sat_v = slf_pkg::SV_W'(fb_q);
			default:             sat_v = '0;
		endcase
		if (sat_v > slf_pkg::SV_W'(slf_pkg::FULL_SCALE)) begin
			clamp_v = (slf_pkg::SAMPLE_W + 1)'(slf_pkg::FULL_SCALE);
		end else if (sat_v < slf_pkg::SV_W'(-slf_pkg::FULL_SCALE - 1)) begin
			clamp_v = (slf_pkg::SAMPLE_W + 1)'(-slf_pkg::FULL_SCALE - 1);
		end else begin
			clamp_v = (slf_pkg::SAMPLE_W + 1)'(sat_v);
		end
		sa_d = clamp_v[slf_pkg::SAMPLE_W] ? slf_pkg::SAMPLE_W'(-clamp_v)
			: slf_pkg::SAMPLE_W'(clamp_v);
	end

	// Saturator back end: the estimate is exact or one low; round the quotient up.
	always_comb begin
		rem0   = n_q[slf_pkg::REM_W-1:0] - prod_q[slf_pkg::REM_W-1:0];
		rem_ge = (rem0 >= slf_pkg::REM_W'(slf_pkg::CUBE_DIV));
		rem1   = rem_ge ? rem0 - slf_pkg::REM_W'(slf_pkg::CUBE_DIV) : rem0;
		q_ceil = (slf_pkg::QUOT_W + 1)'(q0_q) + (slf_pkg::QUOT_W + 1)'(rem_ge)
			+ (slf_pkg::QUOT_W + 1)'(rem1 != '0);
		mag     = sa_q - slf_pkg::SAMPLE_W'(q_ceil);
		sat_res = sneg_q ? slf_pkg::SAMPLE_W'(-mag) : $signed(mag);
	end

	// Filter state: ladder stages and delayed copies of the last stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < slf_pkg::NUM_STAGES; i++) begin
				st_q[i] <= '0;
			end
			for (int i = 0; i < slf_pkg::NUM_DELAYS; i++) begin
				dl_q[i] <= '0;
			end
		end else begin
			if (cmd.fb_ld) begin
				dl_q[2] <= dl_q[1];
				dl_q[1] <= dl_q[0];
				dl_q[0] <= st_q[slf_pkg::NUM_STAGES-1];
			end
			if (cmd.st_upd) begin
				st_q[cmd.stage_idx] <= st_q[cmd.stage_idx] + slf_pkg::STATE_W'(prod_sh);
			end
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (cmd.x_ld) begin
			x_q <= sample_in;
		end
		if (cmd.acc_ld) begin
			acc_q <= slf_pkg::ACC_W'(prod_sh);
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + slf_pkg::ACC_W'(prod_sh);
		end
		if (cmd.fb_ld) begin
			fb_q <= slf_pkg::STATE_W'(acc_q + slf_pkg::ACC_W'(prod_sh));
		end
		if (cmd.sat_ld) begin
			sa_q   <= sa_d;
			sneg_q <= clamp_v[slf_pkg::SAMPLE_W];
		end
		if (cmd.mul_sel == slf_pkg::MS_QE) begin
			n_q <= prod_q[slf_pkg::CUBE_W-1:0];
		end
		if (cmd.mul_sel == slf_pkg::MS_QC) begin
			q0_q <= prod_q[slf_pkg::CUBE_W-1:slf_pkg::RECIP_SH];
		end
		if (cmd.sat_wr) begin
			case (cmd.sat_dst)
				slf_pkg::DST_TGT: tgt_q <= sat_res;
				slf_pkg::DST_OWN: own_q <= sat_res;
				slf_pkg::DST_RES: res_q <= sat_res;
				default: ;
			endcase
		end
		if (cmd.out_ld) begin
			out_data_q <= res_q;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign sample_out   = out_data_q;

endmodule

/* rtl/core/saturating_ladder_lowpass_filter_top.sv */
// Top level of the saturating four-stage ladder low-pass filter.
// Words are handled one at a time: a new input word is taken only in the idle state, after the
// previous result has gone to the output register; all products go through one shared 33x18 multiplier
// and nine saturations.
// Reset (arst_n, asynchronous, active low) clears stages and delays, restores both gains.
module saturating_ladder_lowpass_filter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic                                wr_index,
	input  logic [slf_pkg::CFG_DATA_W-1:0]      wr_data,
	slf_in_if.sink                              in_ch,
	slf_out_if.source                           out_ch
);

	slf_pkg::slf_cmd_t  cmd;
	slf_pkg::slf_sts_t  sts;
	logic               in_ready;

	assign in_ch.ready = in_ready;

	slf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	slf_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.sample_in  (in_ch.sample_in),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.sample_out (out_ch.sample_out)
	);

endmodule

/* rtl/core/slf_checker.sv */
// Port-level checker for the ladder filter, bound to the top level.
module slf_port_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [slf_pkg::SAMPLE_W-1:0]        sample_out
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Words accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= 2'(pend_q + {1'b0, in_acc} - {1'b0, out_acc});
		end
	end

	// The block is busy for a while after taking a word.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready ##1 !in_ready)
		else $error("input taken again right after an accepted word");

	// An offered result word holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("result word dropped or changed while stalled");

	// No result word without an accepted input word.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 2'd0)
		else $error("result word delivered with no word outstanding");

	// At most one word in work and one waiting at the output.
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many words outstanding");

endmodule

bind saturating_ladder_lowpass_filter_top slf_port_checker u_slf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.sample_out (out_ch.sample_out)
);

/* test/slf_checker.sv */
// Scoreboard for the ladder filter: predicts every filtered word and checks the output channel.
module slf_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic                               wr_index,
	input  logic [slf_pkg::CFG_DATA_W-1:0]     wr_data,
	slf_in_if                                  in_ch,
	slf_out_if                                 out_ch,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 words_in,
	output int                                 words_checked
);

	localparam int FRAC = slf_pkg::COEFF_FRAC_BITS;

	// Feedback tap weights on the fixed-point grid, truncated like the hardware constants.
	localparam longint TAP_LAST = (longint'(360891) << FRAC) / 1000000;
	localparam longint TAP_DLY1 = (longint'(417290) << FRAC) / 1000000;
	localparam longint TAP_DLY2 = (longint'(177896) << FRAC) / 1000000;
	localparam longint TAP_DLY3 = (longint'(439725) << FRAC) / 10000000;

	// Saturation curve limits and the cubic divisor.
	localparam longint CLIP_HI   = 32767;
	localparam longint CLIP_LO   = -32768;
	localparam longint CURVE_DIV = longint'(3) * 32767 * 32767;

	logic [slf_pkg::RES_W-1:0]  resonance;
	logic [slf_pkg::CUT_W-1:0]  cutoff;
	logic signed [31:0]         ladder [4];
	logic signed [31:0]         tap_dly [3];
	logic signed [15:0]         filtered_q [$];

	// Floor division by two to the fraction width.
	function automatic longint frac_floor(input longint v);
		return v >>> FRAC;
	endfunction

	// Clamp to the 16-bit range, then bend with u - u^3/3, truncated toward zero.
	function automatic longint ladder_clip(input longint v);
		longint mag;
		longint bent;
		if (v > CLIP_HI)
			v = CLIP_HI;
		if (v < CLIP_LO)
			v = CLIP_LO;
		mag  = (v < 0) ? -v : v;
		bent = (CURVE_DIV * mag - mag * mag * mag) / CURVE_DIV;
		return (v < 0) ? -bent : bent;
	endfunction

	// One-pole step: move a stage toward its target by the cutoff gain, wrapping at 32 bits.
	function automatic logic signed [31:0] stage_nudge(input logic signed [31:0] st,
			input longint target, input longint own);
		longint inc;
		inc = frac_floor((target - own) * longint'(cutoff));
		return 32'(longint'(st) + inc);
	endfunction

	// Advance the filter by one input word and return the expected output word.
	function automatic logic signed [15:0] filter_word(input logic signed [15:0] x);
		longint fb;
		longint gain;
		fb = frac_floor(longint'(ladder[3]) * TAP_LAST)
			+ frac_floor(longint'(tap_dly[0]) * TAP_DLY1)
			+ frac_floor(longint'(tap_dly[1]) * TAP_DLY2)
			+ frac_floor(longint'(tap_dly[2]) * TAP_DLY3);
		tap_dly[2] = tap_dly[1];
		tap_dly[1] = tap_dly[0];
		tap_dly[0] = ladder[3];
		gain = 4 * longint'(resonance);
		ladder[0] = stage_nudge(ladder[0],
			ladder_clip(longint'(x) - frac_floor(gain * fb)), ladder_clip(ladder[0]));
		for (int i = 1; i < 4; i++)
			ladder[i] = stage_nudge(ladder[i], ladder_clip(ladder[i-1]), ladder_clip(ladder[i]));
		return 16'(ladder_clip(fb));
	endfunction

	// Track register writes, predict on accepted input words, compare on accepted output words.
	always @(posedge clk or negedge arst_n) begin
		logic signed [15:0] want;
		if (!arst_n) begin
			resonance = 11'd102;
			cutoff    = 15'd704;
			for (int i = 0; i < 4; i++)
				ladder[i] = '0;
			for (int i = 0; i < 3; i++)
				tap_dly[i] = '0;
			filtered_q.delete();
			fail_count    = 0;
			pending       = 0;
			words_in      = 0;
			words_checked = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					slf_pkg::CFG_RESONANCE: resonance = wr_data[slf_pkg::RES_W-1:0];
					slf_pkg::CFG_CUTOFF:    cutoff    = wr_data[slf_pkg::CUT_W-1:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (filtered_q.size() == 0) begin
					$error("sample_out: unexpected word, expected none, actual %0d",
						out_ch.sample_out);
					fail_count++;
				end else begin
					want = filtered_q.pop_front();
					if (out_ch.sample_out !== want) begin
						$error("sample_out mismatch: expected %0d, actual %0d",
							want, out_ch.sample_out);
						fail_count++;
					end
					words_checked++;
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				filtered_q.push_back(filter_word(in_ch.sample_in));
				words_in++;
			end
			pending = filtered_q.size();
		end
	end

endmodule

/* test/tb.sv */
// Testbench top for the ladder filter: clock, reset, stimulus, gain settings and verdict.
module tb;

	localparam int NUM_SETTINGS = 7;
	localparam int PHASE_WORDS  = 162;

	logic                              clk;
	logic                              arst_n;
	logic                              wr_en;
	logic                              wr_index;
	logic [slf_pkg::CFG_DATA_W-1:0]    wr_data;
	int                                idle_pct;
	int                                stall_left;
	int                                fail_count;
	int                                pending;
	int                                words_in;
	int                                words_checked;
	logic [slf_pkg::CFG_DATA_W-1:0]    res_words [NUM_SETTINGS];
	logic [slf_pkg::CFG_DATA_W-1:0]    cut_words [NUM_SETTINGS];

	slf_in_if  in_ch ();
	slf_out_if out_ch ();

	saturating_ladder_lowpass_filter_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	slf_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.words_in      (words_in),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A hung handshake ends the run here.
	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Output back-pressure: ready is dropped in bursts of random length.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(99) < idle_pct) begin
			out_ch.ready <= 1'b0;
			stall_left = $urandom_range(12, 0);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Mix of full-range noise, rail values and small signals.
	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(9))
			0, 1, 2, 3: return 16'($urandom);
			4:          return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			5, 6:       return 16'($urandom_range(511)) - 16'sd256;
			7:          return 16'($urandom_range(32767));
			default:    return -16'($urandom_range(32768));
		endcase
	endfunction

	// Offer one word, sometimes after a gap that may first wait until the block is ready again.
	task automatic send_word(input logic signed [15:0] s);
		int gap;
		gap = 0;
		if ($urandom_range(99) < idle_pct)
			gap = $urandom_range(13, 1);
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid     <= 1'b0;
			in_ch.sample_in <= 16'($urandom);
			if ($urandom_range(1) == 1) begin
				do @(posedge clk); while (!in_ch.ready);
			end
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= s;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Drop valid and wait until every predicted word has come out.
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_gains(input logic [slf_pkg::CFG_DATA_W-1:0] res_word,
			input logic [slf_pkg::CFG_DATA_W-1:0] cut_word);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= slf_pkg::CFG_RESONANCE;
		wr_data  <= res_word;
		@(negedge clk);
		wr_index <= slf_pkg::CFG_CUTOFF;
		wr_data  <= cut_word;
		@(negedge clk);
		wr_en    <= 1'b0;
	endtask

	initial begin
		logic signed [15:0] directed [20];
		logic signed [15:0] s;
		int count;
		int run;

		arst_n          = 1'b0;
		wr_en           = 1'b0;
		wr_index        = slf_pkg::CFG_RESONANCE;
		wr_data         = '0;
		in_ch.valid     = 1'b0;
		in_ch.sample_in = '0;
		out_ch.ready    = 1'b0;
		stall_left      = 0;
		idle_pct        = 30;

		// Gain settings: zero feedback, full-scale cutoff, resonance beyond range (upper data bits
		// dropped), frozen stages, slowest cutoff with random resonance, random, then back to reset values.
		res_words[0] = 15'd0;
		cut_words[0] = 15'd704;
		res_words[1] = 15'd1024;
		cut_words[1] = 15'd32767;
		res_words[2] = 15'h7fff;
		cut_words[2] = 15'd32767;
		res_words[3] = 15'd2047;
		cut_words[3] = 15'd0;
		res_words[4] = 15'($urandom);
		cut_words[4] = 15'd1;
		res_words[5] = 15'($urandom_range(2047));
		cut_words[5] = 15'($urandom);
		res_words[6] = 15'd102;
		cut_words[6] = 15'd704;

		directed = '{16'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, -16'sd1,
			16'sd1, 16'sh5555, 16'shaaaa, 16'sh00ff, 16'shff00,
			16'sd0, 16'sh7fff, 16'sh8000, 16'sd12345, -16'sd12345};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed words under the reset gains: rails, steps, sign flips, bit patterns.
		foreach (directed[i])
			send_word(directed[i]);

		// Random words under each gain setting; held runs push the stages into saturation.
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			drain();
			write_gains(res_words[p], cut_words[p]);
			idle_pct = (p == NUM_SETTINGS - 1) ? 0 : $urandom_range(60, 5);
			count = 0;
			while (count < PHASE_WORDS) begin
				s   = pick_sample();
				run = ($urandom_range(3) == 0) ? $urandom_range(24, 2) : 1;
				if (run > PHASE_WORDS - count)
					run = PHASE_WORDS - count;
				repeat (run) begin
					send_word(s);
					count++;
				end
			end
		end
		drain();
		repeat (80) @(negedge clk);

		$display("Covered %0d input words and %0d compared output words, over the reset gains",
			words_in, words_checked);
		$display("and %0d written settings spanning zero to full-scale resonance and cutoff.",
			NUM_SETTINGS);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
